// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- rtl/rstree_pkg.sv -----
package rstree_pkg;

	localparam int DEF_CAPACITY = 1024;

	localparam int POS_W   = 11;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 11;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] ADDR_ELEMENT_COUNT = 2'd0;

endpackage

// ----- rtl/range_sum_tree_top.sv -----
// channel   | ports                                         | handshake
// request   | command, position, range_end, new_value       | start high, busy low
// result    | range_sum                                     | done high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata  | apb, pready always high
//
// write: leaf stored at the accepting edge, then a sibling read and a parent update per
//   level up to the root; a write to position 0 or past the element count is dropped
// query: a read of both edges and an accumulate per level walked, and a last read to finish;
//   an empty range answers next cycle
// the node memory has two registered read ports and one write port
// after reset the memory is swept to zero with busy high; no stalls
module range_sum_tree_top
	import rstree_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [POS_W-1:0]             position,
	input  logic [POS_W-1:0]             range_end,
	input  logic signed [VAL_W-1:0]      new_value,
	output logic                         done,
	output logic signed [VAL_W-1:0]      range_sum,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready
);

	localparam int NODE_COUNT = 2 * CAPACITY;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int IDX_W      = NODE_W + 1;
	localparam int WIDE_W     = (IDX_W > POS_W + 1) ? IDX_W : POS_W + 1;

	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
	localparam logic [WIDE_W-1:0] CAP_W     = WIDE_W'(CAPACITY);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WRD   = 3'd2;
	localparam logic [2:0] S_WUPD  = 3'd3;
	localparam logic [2:0] S_QRD   = 3'd4;
	localparam logic [2:0] S_QACC  = 3'd5;

	logic [2:0]         state_q;
	logic [NODE_W-1:0]  clr_q;
	logic [NODE_W-1:0]  cur_q;
	logic [IDX_W-1:0]   l_q;
	logic [IDX_W-1:0]   r_q;
	logic [VAL_W-1:0]   acc_q;
	logic               done_q;
	logic [VAL_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;

	logic [VAL_W-1:0]   mem [NODE_COUNT];
	logic [VAL_W-1:0]   rd_a_q;
	logic [VAL_W-1:0]   rd_b_q;

	logic               accept;
	logic               cfg_wr;
	logic [WIDE_W-1:0]  pos_w;
	logic [WIDE_W-1:0]  end_w;
	logic [WIDE_W-1:0]  cnt_w;
	logic [WIDE_W-1:0]  eff_w;
	logic [WIDE_W-1:0]  lo_w;
	logic [WIDE_W-1:0]  hi_w;
	logic [WIDE_W-1:0]  leaf_w;
	logic [WIDE_W-1:0]  qlo_w;
	logic [WIDE_W-1:0]  qhi_w;
	logic               wr_ok;
	logic               q_ok;
	logic [NODE_W-1:0]  parent;
	logic [IDX_W-1:0]   r_m1;
	logic [VAL_W-1:0]   up_sum;
	logic [VAL_W-1:0]   add_a;
	logic [VAL_W-1:0]   add_b;
	logic               we;
	logic [NODE_W-1:0]  waddr;
	logic [VAL_W-1:0]   wdata;
	logic [NODE_W-1:0]  ra;
	logic [NODE_W-1:0]  rb;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign range_sum = sum_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = (paddr == ADDR_ELEMENT_COUNT) ? APB_DATA_W'(count_q) : '0;

	// clip the request against the element count and capacity
	always_comb begin
		pos_w  = WIDE_W'(position);
		end_w  = WIDE_W'(range_end);
		cnt_w  = WIDE_W'(count_q);
		eff_w  = (cnt_w > CAP_W) ? CAP_W : cnt_w;
		lo_w   = (pos_w == '0) ? WIDE_W'(1) : pos_w;
		hi_w   = (end_w > eff_w) ? eff_w : end_w;
		leaf_w = CAP_W + pos_w - WIDE_W'(1);
		qlo_w  = CAP_W + lo_w - WIDE_W'(1);
		qhi_w  = CAP_W + hi_w;
		wr_ok  = (pos_w != '0) && (pos_w <= eff_w);
		q_ok   = (lo_w <= hi_w);
	end

	assign parent = cur_q >> 1;
	assign r_m1   = r_q - IDX_W'(1);
	assign up_sum = acc_q + rd_a_q;
	assign add_a  = l_q[0] ? rd_a_q : '0;
	assign add_b  = r_q[0] ? rd_b_q : '0;
	assign ra     = (state_q == S_WRD) ? (cur_q ^ ROOT_NODE) : l_q[NODE_W-1:0];
	assign rb     = r_m1[NODE_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = leaf_w[NODE_W-1:0];
		wdata = new_value;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_WUPD) begin
			we    = 1'b1;
			waddr = parent;
			wdata = up_sum;
		end else if (accept && command == CMD_WRITE && wr_ok) begin
			we = 1'b1;
		end
	end

	// node memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_wr && paddr == ADDR_ELEMENT_COUNT) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_WRITE) begin
							if (wr_ok) begin
								state_q <= S_WRD;
							end
						end else if (q_ok) begin
							state_q <= S_QRD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_WRD: begin
					state_q <= S_WUPD;
				end
				S_WUPD: begin
					state_q <= (parent == ROOT_NODE) ? S_IDLE : S_WRD;
				end
				S_QRD: begin
					if (l_q < r_q) begin
						state_q <= S_QACC;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_QACC: begin
					state_q <= S_QRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cur_q <= leaf_w[NODE_W-1:0];
			acc_q <= (command == CMD_WRITE) ? new_value : '0;
			l_q   <= qlo_w[IDX_W-1:0];
			r_q   <= qhi_w[IDX_W-1:0];
			sum_q <= '0;
		end else if (state_q == S_WUPD) begin
			cur_q <= parent;
			acc_q <= up_sum;
		end else if (state_q == S_QACC) begin
			acc_q <= acc_q + add_a + add_b;
			l_q   <= (l_q + IDX_W'(l_q[0])) >> 1;
			r_q   <= r_q >> 1;
		end else if (state_q == S_QRD && !(l_q < r_q)) begin
			sum_q <= acc_q;
		end
	end

endmodule

// ----- rtl/rstree_checker.sv -----
`include "assert_macros.svh"

module rstree_checker
	import rstree_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    command,
	input logic                    done,
	input logic                    psel,
	input logic                    penable,
	input logic                    pwrite,
	input logic [APB_ADDR_W-1:0]   paddr,
	input logic [APB_DATA_W-1:0]   pwdata,
	input logic [APB_DATA_W-1:0]   prdata,
	input logic                    pready
);

	logic req_wr;
	logic req_q;
	logic cfg_cnt_wr;

	assign req_wr     = start && !busy && command == CMD_WRITE;
	assign req_q      = start && !busy && command == CMD_QUERY;
	assign cfg_cnt_wr = psel && penable && pwrite && pready && paddr == ADDR_ELEMENT_COUNT;

	// a result leaves the block idle
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)
	// a write request never produces a result
	`ASSERT_NEXT(a_write_silent, clk, arst_n, req_wr, !done)
	// a query either answers at once or keeps the block busy
	`ASSERT_NEXT(a_query_progress, clk, arst_n, req_q, busy || done)
	// the count register reads back what was written
	`ASSERT_NEXT(a_count_readback, clk, arst_n, cfg_cnt_wr,
		paddr != ADDR_ELEMENT_COUNT || prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))

endmodule

bind range_sum_tree_top rstree_checker u_rstree_checker (.*);
